@@ design/efre_pkg.sv @@
`timescale 1ns / 1ps

package efre_pkg;

  // Field widths
  localparam int FRAME_W = 16;
  localparam int HL_W    = 16;
  localparam int RATE_W  = 32;

  // Exponent x = d / half_life in Q32: 16 integer bits, 32 fraction bits
  localparam int XFRAC_W = 32;
  localparam int X_W     = FRAME_W + XFRAC_W;

  // Weights are Q30 in 31 bits so that 1.0 fits
  localparam int W_W = 31;
  localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1) << 30;
  localparam logic [29:0]    LN2_Q30    = 30'd744261118;

  localparam logic [10:0] ZERO_GAIN  = 11'd2000;
  localparam logic [9:0]  INST_SCALE = 10'd1000;

  localparam logic [HL_W-1:0] HALF_LIFE_RESET = 16'd1000;

  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam int RATE_FRAC_BITS_DEF = 16;
  localparam int MAX_TABLE_BITS     = 12;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // One classified frame, as it travels from the front end to the back end
  typedef struct packed {
    logic               is_zero;
    logic [FRAME_W-1:0] frame_ms;
    logic [X_W-1:0]     x_num;
  } efre_item_t;

  typedef struct packed {
    logic busy;
    logic load;
  } efre_back_stat_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] res;
    logic [63:0] b;
    r   = v;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (r >= res + b) begin
        r   = r - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b + (64'd1 << 29);
    return p >> 30;
  endfunction

  // Entry idx of the table 2^(-idx/2^tb) in Q30, evaluated at elaboration
  function automatic logic [63:0] pow_entry(int tb, int idx);
    logic [63:0] st [MAX_TABLE_BITS];
    logic [63:0] s;
    logic [63:0] v;
    s = 64'd1 << 29;
    for (int k = 0; k < MAX_TABLE_BITS; k++) begin
      st[k] = '0;
    end
    for (int k = 1; k <= tb; k++) begin
      s = isqrt64(s << 30);
      st[tb - k] = s;
    end
    v = 64'd1 << 30;
    for (int j = MAX_TABLE_BITS - 1; j >= 0; j--) begin
      if (j < tb && ((idx >> j) & 1) != 0) begin
        v = mul_q30(v, st[j]);
      end
    end
    return v;
  endfunction

endpackage

@@ design/efre_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module efre_div #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0] rem_shift;
  logic [DIVISOR_W:0] rem_diff;
  logic               take;

  assign rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_q};
  assign take      = rem_shift >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DIVIDEND_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], take};
      rem_q <= take ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ design/efre_front.sv @@
`timescale 1ns / 1ps

// Accept a frame, classify it and form the exponent dividend
module efre_front import efre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [FRAME_W-1:0] s_frame_i,
  input  logic [HL_W-1:0]    hl_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output efre_item_t         item_o
);

  logic       valid_q;
  efre_item_t item_q;
  efre_item_t item_d;
  logic       take;

  always_comb begin
    item_d.is_zero  = (s_frame_i == '0);
    item_d.frame_ms = s_frame_i;
    // zero length stands for a half-millisecond frame: numerator 0.5 * 2^32
    item_d.x_num    = (item_d.is_zero ? (X_W'(1) << (XFRAC_W - 1))
                                      : {s_frame_i, XFRAC_W'(0)})
                      + X_W'(hl_i >> 1);
  end

  assign s_ready_o = !valid_q || item_ready_i;
  assign take      = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ design/efre_fifo.sv @@
`timescale 1ns / 1ps

// Short queue between front end and back end
module efre_fifo import efre_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  efre_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output efre_item_t out_item_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  efre_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (cnt_q != CNT_W'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

@@ design/efre_back.sv @@
`timescale 1ns / 1ps

// Weight, blend and saturate one frame at a time
module efre_back import efre_pkg::*; #(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF,
  parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  efre_item_t        item_i,
  input  logic [HL_W-1:0]   hl_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [RATE_W-1:0] rate_o,
  output logic              sat_o,
  output efre_back_stat_t   stat_o
);

  localparam int TABLE_SIZE = 1 << EXP_TABLE_BITS;
  localparam int REM_W      = XFRAC_W - EXP_TABLE_BITS;
  localparam int INST_W     = 10 + RATE_FRAC_BITS;
  localparam int MUL_B_W    = (INST_W > W_W) ? INST_W : W_W;
  localparam int PROD_W     = RATE_W + MUL_B_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam logic [INST_W-1:0] INST_NUM = INST_W'(INST_SCALE) << RATE_FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_CORR  = 8'b0000_0100,
    S_MANT  = 8'b0000_1000,
    S_WGT   = 8'b0001_0000,
    S_PRODA = 8'b0010_0000,
    S_PRODB = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [W_W-1:0] pow_tab [TABLE_SIZE];

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_tab
    assign pow_tab[g] = W_W'(pow_entry(EXP_TABLE_BITS, g));
  end

  logic                zero_q;
  logic [X_W-1:0]      x_q;
  logic [INST_W-1:0]   inst_q;
  logic [W_W-1:0]      w_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   acc_q;
  logic [RATE_W-1:0]   rate_q;
  logic                out_valid_q;
  logic [RATE_W-1:0]   out_rate_q;
  logic                out_sat_q;

  logic                start;
  logic                dx_done;
  logic [X_W-1:0]      dx_quo;
  logic                di_done;
  logic [INST_W-1:0]   di_quo;

  efre_div #(
    .DIVIDEND_W(X_W),
    .DIVISOR_W (HL_W)
  ) u_div_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .dividend_i(item_i.x_num),
    .divisor_i (hl_i),
    .done_o    (dx_done),
    .quotient_o(dx_quo)
  );

  efre_div #(
    .DIVIDEND_W(INST_W),
    .DIVISOR_W (FRAME_W)
  ) u_div_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .dividend_i(INST_NUM),
    .divisor_i (item_i.frame_ms),
    .done_o    (di_done),
    .quotient_o(di_quo)
  );

  logic [EXP_TABLE_BITS-1:0] f_idx;
  logic [REM_W-1:0]          r_frac;
  logic [FRAME_W-1:0]        shift_n;
  logic [PROD_W-1:0]         corr_round;
  logic [W_W-1:0]            corr;
  logic [PROD_W-1:0]         mant_round;
  logic [W_W-1:0]            mant;
  logic [W_W-1:0]            w_next;
  logic [W_W-1:0]            one_minus_w;
  logic [RATE_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic [SUM_W-1:0]          sum_pos;
  logic [PROD_W-1:0]         inc_round;
  logic [PROD_W-1:0]         inc;
  logic [SUM_W-1:0]          next_raw;
  logic                      next_sat;
  logic [RATE_W-1:0]         next_rate;
  logic                      can_load;
  logic                      load;

  assign f_idx   = x_q[XFRAC_W-1 -: EXP_TABLE_BITS];
  assign r_frac  = x_q[REM_W-1:0];
  assign shift_n = x_q[X_W-1:XFRAC_W];

  assign corr_round  = prod_q + (PROD_W'(1) << 31);
  assign corr        = WEIGHT_ONE - corr_round[32 +: W_W];
  assign mant_round  = prod_q + (PROD_W'(1) << 29);
  assign mant        = mant_round[30 +: W_W];
  assign w_next      = (shift_n >= FRAME_W'(32)) ? '0 : (mant >> shift_n[4:0]);
  assign one_minus_w = WEIGHT_ONE - w_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_CORR: begin
        mul_a = RATE_W'(r_frac);
        mul_b = MUL_B_W'(LN2_Q30);
      end
      S_MANT: begin
        mul_a = RATE_W'(pow_tab[f_idx]);
        mul_b = MUL_B_W'(corr);
      end
      S_PRODA: begin
        if (zero_q) begin
          mul_a = RATE_W'(one_minus_w);
          mul_b = MUL_B_W'(ZERO_GAIN);
        end else begin
          mul_a = rate_q;
          mul_b = MUL_B_W'(w_q);
        end
      end
      S_PRODB: begin
        mul_a = RATE_W'(one_minus_w);
        mul_b = MUL_B_W'(inst_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // acc_q holds the first product, prod_q the second
  assign sum_pos   = SUM_W'(acc_q) + SUM_W'(prod_q) + (SUM_W'(1) << 29);
  assign inc_round = acc_q + (PROD_W'(1) << (29 - RATE_FRAC_BITS));
  assign inc       = inc_round >> (30 - RATE_FRAC_BITS);
  assign next_raw  = zero_q ? (SUM_W'(rate_q) + SUM_W'(inc)) : (sum_pos >> 30);
  assign next_sat  = |next_raw[SUM_W-1:RATE_W];
  assign next_rate = next_sat ? '1 : next_raw[RATE_W-1:0];

  assign can_load     = !out_valid_q || m_ready_i;
  assign load         = (state_q == S_FIN) && can_load;
  assign item_ready_o = (state_q == S_IDLE);
  assign start        = item_valid_i && item_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_DIV;
      S_DIV:   if (dx_done && di_done) state_d = S_CORR;
      S_CORR:  state_d = S_MANT;
      S_MANT:  state_d = S_WGT;
      S_WGT:   state_d = S_PRODA;
      S_PRODA: state_d = S_PRODB;
      S_PRODB: state_d = S_FIN;
      S_FIN:   if (can_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        rate_q      <= next_rate;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      zero_q <= item_i.is_zero;
    end
    if ((state_q == S_DIV) && dx_done && di_done) begin
      x_q    <= dx_quo;
      inst_q <= di_quo;
    end
    if (state_q == S_WGT) begin
      w_q <= w_next;
    end
    if (state_q != S_FIN) begin
      prod_q <= mul_p;
    end
    if (state_q == S_PRODB) begin
      acc_q <= prod_q;
    end
    if (load) begin
      out_rate_q <= next_rate;
      out_sat_q  <= next_sat;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign rate_o      = out_rate_q;
  assign sat_o       = out_sat_q;
  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.load = load;

endmodule

@@ design/ema_frame_rate_estimator.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Transfer when              Payload
// s_axis    in         s_axis_tvalid & tready     tdata[15:0] frame_ms
// m_axis    out        m_axis_tvalid & tready     tdata[31:0] rate_out, tuser[0] rate_saturated
// cfg       in         cfg_we_i                   cfg_wdata_i[15:0] half_life_ms
//
// Each frame runs through the back-end steps in order: a start, the exponent quotient
// (48 bits with the default widths, one per cycle of the restoring divider, then a check
// that it is done) and then the correction, mantissa, weight, two blend products and the load.
// Reset clears the estimate to zero and sets the half-life to 1000 ms; there is no
// clearing pass. The front stage and queue keep taking frames while the back end
// works. While a finished result waits in the output register, the back end holds in its
// last step; the input stalls only once the queue and the front stage are full as well.
module ema_frame_rate_estimator import efre_pkg::*; #(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF,
  parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] frame_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] rate_out
  output logic [0:0]  m_axis_tuser    // [0] rate_saturated
);

  // Half-life register; a zero half-life acts as one millisecond
  logic [HL_W-1:0] hl_q;
  logic [HL_W-1:0] hl_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q <= HALF_LIFE_RESET;
    end else if (cfg_we_i) begin
      hl_q <= cfg_wdata_i;
    end
  end

  assign hl_eff = (hl_q == '0) ? HL_W'(1) : hl_q;

  // Front end: classify the frame and build the exponent dividend
  logic       fr_valid;
  logic       fr_ready;
  efre_item_t fr_item;

  efre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_frame_i   (s_axis_tdata),
    .hl_i        (hl_eff),
    .item_valid_o(fr_valid),
    .item_ready_i(fr_ready),
    .item_o      (fr_item)
  );

  // Queue: decouple the front end from the long back-end sequence
  logic       q_valid;
  logic       q_ready;
  efre_item_t q_item;

  efre_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_ready_o (fr_ready),
    .in_item_i  (fr_item),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_item_o (q_item)
  );

  // Back end: divide, weight, blend, saturate and hold the result
  efre_back_stat_t back_stat;
  logic            rate_sat;

  efre_back #(
    .EXP_TABLE_BITS(EXP_TABLE_BITS),
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_i      (q_item),
    .hl_i        (hl_eff),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .rate_o      (m_axis_tdata),
    .sat_o       (rate_sat),
    .stat_o      (back_stat)
  );

  assign m_axis_tuser = rate_sat;

  // A clamped result always carries the largest code
  a_sat_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '1)
    else $error("saturated result is not at full scale");

  // Never overwrite a result that still waits for its transfer
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

  // The back end only starts on an item taken from the queue
  a_start_from_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(back_stat.busy) |-> $past(q_valid))
    else $error("back end started without a queued item");

endmodule
